// ----- hdl/vls_pkg.sv -----
// Shared types, codes and character helpers for the vision link supervisor.
`default_nettype none

package vls_pkg;

    // Longest frame in bytes and derived widths
    localparam int FRAME_MAX = 24;
    localparam int POS_W     = $clog2(FRAME_MAX);
    localparam int NUM_W     = 16;
    localparam int BCD_W     = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BOOT_PING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PING_IVL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFLINE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NA_TIMEOUT  = 3'd4;

    // Input actions
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_PONG  = 3'd1;
    localparam logic [2:0] ACT_X     = 3'd2;
    localparam logic [2:0] ACT_START = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;
    localparam logic [2:0] ACT_ACK   = 3'd5;

    // Frame characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_TICK,
        ST_CONVERT,
        ST_EMIT,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         task_id;
        logic [15:0]        pong_id;
        logic               x_valid;
        logic               x_na;
        logic signed [15:0] x_pixel;
        logic [15:0]        ack_run_id;
        logic [7:0]         ack_task_id;
        logic               ack_start;
    } in_word_t;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               last;
        logic               online;
        logic [15:0]        ping_id;
        logic               x_seen;
        logic               x_fresh_valid;
        logic               x_fresh_na;
        logic signed [15:0] pixel;
        logic               ack_matched;
        logic               ack_is_start;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic             capture;
        logic             apply;
        logic             tick_eval;
        logic             conv_step;
        logic             emit;
        logic             report;
        logic [POS_W-1:0] pos;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic frame_now;
        logic out_free;
        logic last_pos;
    } dp_stat_t;

    // Upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        case (v)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vls_ctrl.sv -----
// Sequencing state machine: apply, tick evaluation, conversion and word emission.
`default_nettype none

module vls_ctrl
    import vls_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [POS_W-1:0] CONV_LAST = POS_W'(NUM_W - 1);

    state_t           state_reg, state_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (stat.is_tick)
                    state_next = ST_TICK;
                else if (stat.frame_now)
                    state_next = ST_CONVERT;
                else
                    state_next = ST_REPORT;
            end
            ST_TICK:
            begin
                state_next = stat.frame_now ? ST_CONVERT : ST_REPORT;
            end
            ST_CONVERT:
            begin
                if (cnt_reg == CONV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.last_pos)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        in_stall      = (state_reg != ST_IDLE);
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.apply     = (state_reg == ST_APPLY);
        cmd.tick_eval = (state_reg == ST_TICK);
        cmd.conv_step = (state_reg == ST_CONVERT);
        cmd.emit      = (state_reg == ST_EMIT) && stat.out_free;
        cmd.report    = (state_reg == ST_REPORT) && stat.out_free;
        cmd.pos       = cnt_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/vls_datapath.sv -----
// Link state, configuration, decimal conversion, frame byte generation and output word.
`default_nettype none

module vls_datapath
    import vls_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire in_word_t              in_word,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output out_word_t                  out_word
);

    // Configuration
    logic [7:0]  boot_cnt_reg;
    logic [15:0] ping_ivl_reg, offline_reg, x_to_reg, na_to_reg;

    // Link state
    in_word_t    in_reg;
    logic [31:0] time_now_reg, ping_time_reg, pong_time_reg, x_time_reg;
    logic [15:0] next_ping_reg, awaited_reg, run_cnt_reg, sent_run_reg;
    logic [7:0]  active_reg, sent_task_reg, pings_done_reg;
    logic        sent_start_reg;
    logic        has_pong_reg, ping_sent_reg, x_seen_reg, x_valid_reg, x_na_reg;
    logic signed [15:0] pixel_reg;
    logic [15:0] ack_run_reg;
    logic [7:0]  ack_task_reg;
    logic        ack_start_reg, ack_ok_reg;

    // Frame description and conversion
    logic             frm_task_reg, frm_start_reg;
    logic [2:0]       frm_tid_reg;
    logic [NUM_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [7:0]       chk_reg;

    logic      out_valid_reg;
    out_word_t out_reg;

    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] then,
                                     input logic [15:0] period);
        logic [31:0] diff;
        diff = now - then;
        return diff >= {16'd0, period};
    endfunction

    logic [15:0] np_inc, rc_inc;
    logic        start_ok, stop_ok, ping_ok;

    assign np_inc   = (next_ping_reg == 16'hFFFF) ? 16'd1 : next_ping_reg + 16'd1;
    assign rc_inc   = (run_cnt_reg == 16'hFFFF) ? 16'd1 : run_cnt_reg + 16'd1;
    assign start_ok = (in_reg.task_id >= 8'd1) && (in_reg.task_id <= 8'd6);
    assign stop_ok  = (active_reg != 8'd0) && (in_reg.task_id == active_reg);
    assign ping_ok  = (pings_done_reg < boot_cnt_reg) &&
                      (!ping_sent_reg || elapsed(time_now_reg, ping_time_reg, ping_ivl_reg));

    // Decide whether the current step opens a frame
    always_comb
    begin
        case (in_reg.action)
            ACT_TICK:  stat.frame_now = ping_ok;
            ACT_START: stat.frame_now = start_ok;
            ACT_STOP:  stat.frame_now = stop_ok;
            default:   stat.frame_now = 1'b0;
        endcase
    end
    assign stat.is_tick = (in_reg.action == ACT_TICK);

    // Capture the accepted input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_word;
    end

    // Hold configuration and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_cnt_reg   <= 8'd3;
            ping_ivl_reg   <= 16'd500;
            offline_reg    <= 16'd3000;
            x_to_reg       <= 16'd100;
            na_to_reg      <= 16'd250;
            time_now_reg   <= '0;
            ping_time_reg  <= '0;
            pong_time_reg  <= '0;
            x_time_reg     <= '0;
            next_ping_reg  <= '0;
            awaited_reg    <= '0;
            run_cnt_reg    <= '0;
            sent_run_reg   <= '0;
            active_reg     <= '0;
            sent_task_reg  <= '0;
            pings_done_reg <= '0;
            sent_start_reg <= 1'b0;
            has_pong_reg   <= 1'b0;
            ping_sent_reg  <= 1'b0;
            x_seen_reg     <= 1'b0;
            x_valid_reg    <= 1'b0;
            x_na_reg       <= 1'b0;
            pixel_reg      <= '0;
            ack_run_reg    <= '0;
            ack_task_reg   <= '0;
            ack_start_reg  <= 1'b0;
            ack_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOOT_PING:  boot_cnt_reg <= cfg_data[7:0];
                    REG_PING_IVL:   ping_ivl_reg <= cfg_data;
                    REG_OFFLINE:    offline_reg  <= cfg_data;
                    REG_X_TIMEOUT:  x_to_reg     <= cfg_data;
                    REG_NA_TIMEOUT: na_to_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.apply)
            begin
                case (in_reg.action)
                    ACT_TICK: time_now_reg <= time_now_reg + 32'd1;
                    ACT_PONG:
                    begin
                        if (in_reg.pong_id == awaited_reg)
                        begin
                            pong_time_reg <= time_now_reg;
                            has_pong_reg  <= 1'b1;
                        end
                    end
                    ACT_X:
                    begin
                        x_time_reg  <= time_now_reg;
                        x_seen_reg  <= 1'b1;
                        x_valid_reg <= in_reg.x_valid;
                        x_na_reg    <= in_reg.x_na;
                        pixel_reg   <= in_reg.x_pixel;
                    end
                    ACT_START:
                    begin
                        if (start_ok)
                        begin
                            run_cnt_reg    <= rc_inc;
                            active_reg     <= in_reg.task_id;
                            sent_run_reg   <= rc_inc;
                            sent_task_reg  <= in_reg.task_id;
                            sent_start_reg <= 1'b1;
                        end
                    end
                    ACT_STOP:
                    begin
                        if (stop_ok)
                        begin
                            sent_run_reg   <= run_cnt_reg;
                            sent_task_reg  <= in_reg.task_id;
                            sent_start_reg <= 1'b0;
                            active_reg     <= 8'd0;
                        end
                    end
                    ACT_ACK:
                    begin
                        ack_run_reg   <= in_reg.ack_run_id;
                        ack_task_reg  <= in_reg.ack_task_id;
                        ack_start_reg <= in_reg.ack_start;
                        ack_ok_reg    <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.tick_eval)
            begin
                // Forget an expired pong, then send a boot ping when due
                if (has_pong_reg && elapsed(time_now_reg, pong_time_reg, offline_reg))
                    has_pong_reg <= 1'b0;
                if (ping_ok)
                begin
                    next_ping_reg  <= np_inc;
                    awaited_reg    <= np_inc;
                    ping_time_reg  <= time_now_reg;
                    ping_sent_reg  <= 1'b1;
                    pings_done_reg <= pings_done_reg + 8'd1;
                end
            end
        end
    end

    logic [2:0]       ndig;
    logic [POS_W-1:0] flen, pos, tail, rel;
    logic [2:0]       didx;
    logic [7:0]       frame_byte;
    logic             is_payload;

    // Load the frame description and run the binary to BCD conversion
    logic [BCD_W-1:0] bcd_adj;
    always_comb
    begin
        for (int i = 0; i < BCD_W / 4; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    logic frame_load;
    assign frame_load = (cmd.apply && !stat.is_tick && stat.frame_now) ||
                        (cmd.tick_eval && stat.frame_now);

    always_ff @(posedge clk)
    begin
        if (frame_load)
        begin
            frm_task_reg  <= !stat.is_tick;
            frm_start_reg <= (in_reg.action == ACT_START);
            frm_tid_reg   <= in_reg.task_id[2:0];
            bcd_reg       <= '0;
            chk_reg       <= '0;
            case (in_reg.action)
                ACT_START: bin_reg <= rc_inc;
                ACT_STOP:  bin_reg <= run_cnt_reg;
                default:   bin_reg <= np_inc;
            endcase
        end
        else if (cmd.conv_step)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
            bin_reg <= {bin_reg[NUM_W-2:0], 1'b0};
        end
        else if (cmd.emit && is_payload)
            chk_reg <= chk_reg ^ frame_byte;
    end

    // Work out digit count, frame length and the byte at the current position
    always_comb
    begin
        if (bcd_reg[19:16] != 4'd0)      ndig = 3'd5;
        else if (bcd_reg[15:12] != 4'd0) ndig = 3'd4;
        else if (bcd_reg[11:8] != 4'd0)  ndig = 3'd3;
        else if (bcd_reg[7:4] != 4'd0)   ndig = 3'd2;
        else                             ndig = 3'd1;

        pos = cmd.pos;
        if (!frm_task_reg)
            flen = POS_W'(11) + POS_W'(ndig);
        else if (frm_start_reg)
            flen = POS_W'(19) + POS_W'(ndig);
        else
            flen = POS_W'(18) + POS_W'(ndig);

        tail       = flen - POS_W'(1) - pos;
        rel        = pos - POS_W'(ndig);
        didx       = ndig + 3'd5 - pos[2:0];
        is_payload = (pos != '0) && (tail > POS_W'(4));
        frame_byte = CH_DOLLAR;

        if (pos == '0)
            frame_byte = CH_DOLLAR;
        else if (pos <= POS_W'(5))
        begin
            case (pos[2:0])
                3'd1:    frame_byte = frm_task_reg ? 8'h54 : 8'h50;
                3'd2:    frame_byte = frm_task_reg ? 8'h41 : 8'h49;
                3'd3:    frame_byte = frm_task_reg ? 8'h53 : 8'h4E;
                3'd4:    frame_byte = frm_task_reg ? 8'h4B : 8'h47;
                default: frame_byte = CH_COMMA;
            endcase
        end
        else if (pos < POS_W'(6) + POS_W'(ndig))
        begin
            case (didx)
                3'd0:    frame_byte = CH_ZERO + {4'd0, bcd_reg[3:0]};
                3'd1:    frame_byte = CH_ZERO + {4'd0, bcd_reg[7:4]};
                3'd2:    frame_byte = CH_ZERO + {4'd0, bcd_reg[11:8]};
                3'd3:    frame_byte = CH_ZERO + {4'd0, bcd_reg[15:12]};
                default: frame_byte = CH_ZERO + {4'd0, bcd_reg[19:16]};
            endcase
        end
        else if (tail <= POS_W'(4))
        begin
            case (tail[2:0])
                3'd4:    frame_byte = CH_STAR;
                3'd3:    frame_byte = hex_char(chk_reg[7:4]);
                3'd2:    frame_byte = hex_char(chk_reg[3:0]);
                3'd1:    frame_byte = CH_CR;
                default: frame_byte = CH_LF;
            endcase
        end
        else
        begin
            // Task fields: comma, task digit, comma, then START or STOP
            case (rel)
                POS_W'(6):  frame_byte = CH_COMMA;
                POS_W'(7):  frame_byte = CH_ZERO + {5'd0, frm_tid_reg};
                POS_W'(8):  frame_byte = CH_COMMA;
                POS_W'(9):  frame_byte = 8'h53;
                POS_W'(10): frame_byte = 8'h54;
                POS_W'(11): frame_byte = frm_start_reg ? 8'h41 : 8'h4F;
                POS_W'(12): frame_byte = frm_start_reg ? 8'h52 : 8'h50;
                default:    frame_byte = 8'h54;
            endcase
        end
    end

    assign stat.last_pos = (tail == '0);
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Hold the output word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.report)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.report)
        begin
            out_reg.tx_valid      <= cmd.emit;
            out_reg.tx_byte       <= cmd.emit ? frame_byte : 8'd0;
            out_reg.last          <= cmd.emit ? stat.last_pos : 1'b1;
            out_reg.online        <= has_pong_reg &&
                                     !elapsed(time_now_reg, pong_time_reg, offline_reg);
            out_reg.ping_id       <= awaited_reg;
            out_reg.x_seen        <= x_seen_reg;
            out_reg.x_fresh_valid <= x_seen_reg && x_valid_reg &&
                                     !elapsed(time_now_reg, x_time_reg, x_to_reg);
            out_reg.x_fresh_na    <= x_seen_reg && x_na_reg &&
                                     !elapsed(time_now_reg, x_time_reg, na_to_reg);
            out_reg.pixel         <= pixel_reg;
            out_reg.ack_matched   <= ack_ok_reg && (ack_run_reg == sent_run_reg) &&
                                     (ack_task_reg == sent_task_reg) &&
                                     (ack_start_reg == sent_start_reg);
            out_reg.ack_is_start  <= ack_start_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

// ----- hdl/vision_link_supervisor_unit.sv -----
// Top level of the vision link supervisor: controller and datapath.
`default_nettype none

// One word in at a time. A pong, X report, ack or ignored command that sends
// nothing gives a single status word, loaded into the output register from
// the report state after the apply state (and the tick state for a tick), and
// the next word is taken once the unit is back in idle. A word that sends a
// frame first runs the serial binary-to-decimal conversion of its id and then
// delivers one frame byte per cycle while the output is not stalled (12 to 24
// bytes). in_stall stays high from acceptance until the last result is loaded
// into the output register. Configuration writes are always ready.

module vision_link_supervisor_unit
    import vls_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_word,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    vls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    vls_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ----- hdl/vls_checker.sv -----
// Port-level checks for the vision link supervisor, bound to the top level.
`default_nettype none

module vls_checker
    import vls_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    // A stalled word stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // Busy right after an accepted word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before results");

    // A status-only word closes its item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.tx_valid |-> out_word.last && out_word.tx_byte == 8'd0)
        else $error("status word malformed");

    // A frame ends in line feed
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.tx_valid && out_word.last |-> out_word.tx_byte == CH_LF)
        else $error("frame does not end in line feed");

endmodule

bind vision_link_supervisor_unit vls_checker u_vls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire
